// ----- sv/ksa_pkg.sv -----
// Shared types and constants for the key slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package ksa_pkg;

	localparam int SLOT_W    = 6;
	localparam int HANDLE_W  = 32;
	localparam int MAX_SLOTS = 63;
	localparam int TBL_DEPTH = MAX_SLOTS + 1;

	// Slot lifecycle states.
	localparam logic [1:0] SS_AVAILABLE = 2'd0;
	localparam logic [1:0] SS_ASSIGNED  = 2'd1;
	localparam logic [1:0] SS_KILLED    = 2'd2;
	localparam logic [1:0] SS_RELEASED  = 2'd3;

	// Operation codes.
	localparam logic [2:0] M_RESERVE   = 3'd0;
	localparam logic [2:0] M_LOOKUP    = 3'd1;
	localparam logic [2:0] M_DESTROY   = 3'd2;
	localparam logic [2:0] M_REF_REL   = 3'd3;
	localparam logic [2:0] M_ABORT_REL = 3'd4;
	localparam logic [2:0] M_SWEEP     = 3'd5;

	typedef struct packed {
		logic [1:0]          state;
		logic [HANDLE_W-1:0] owner;
	} slot_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_entry_t       entry;
	} tbl_wr_t;

endpackage

`default_nettype wire

// ----- sv/key_slot_allocator_core.sv -----
// Key slot allocator top level: command sequencer, slot scan and result output.
//
// Usage: commands enter on the s_axis channel, one beat per command, with the
// operation code in s_axis_tuser. Each command yields one result beat on
// m_axis, except a clear sweep, which yields one beat per released slot (with
// m_axis_tuser set as a clear-key programming request) or a single beat with
// slot 0 when no slot is released. m_axis_tlast marks the final beat of a
// command. The cfg channel writes the number of active slots and reloads the
// free count; the user must write it only while no command is in flight, as
// the block does not check this. The block scans the slot table through one
// memory read port, one slot per cycle unless a sweep stall holds it, and
// evaluates each entry with one compare/update unit. A command stops at its
// first hit; a lookup miss or a sweep scans every active slot. Release
// commands touch one slot; illegal or trivially empty commands skip the table.
// s_axis_tready is high only between commands.
// Reset: the table reads as all slots available with no owner (the valid bits
// clear asynchronously), active slots and free count return to 63.
// Stalls: results sit in an output register; a sweep pauses its scan while a
// result beat is held by a stalled receiver, and nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module key_slot_allocator_core (
	input  wire                              clk,
	input  wire                              arst_n,
	// Command channel.
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata: [31:0] owner_handle, [37:32] slot_index, [39:38] zero.
	input  wire  [39:0]                      s_axis_tdata,
	// tuser: [2:0] mode.
	input  wire  [2:0]                       s_axis_tuser,
	// Result channel.
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// tdata: [5:0] slot_number, [11:6] free_slots, [15:12] zero.
	output logic [15:0]                      m_axis_tdata,
	// tuser: [0] clear_request.
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast,
	// Configuration channel: active slot count.
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [ksa_pkg::SLOT_W-1:0]       cfg_data
);
	import ksa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [SLOT_W-1:0]   active_q;
	logic [SLOT_W-1:0]   free_count_q;

	// Command held for the length of the scan.
	logic [2:0]          mode_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SLOT_W:0]     iss_addr_q;
	logic [SLOT_W-1:0]   end_q;

	// Entry under evaluation (table read data arrives in the cycle after its address).
	logic                ev_vld_s1;
	logic [SLOT_W-1:0]   ev_addr_s1;

	// Result waiting to leave; a sweep keeps its latest hit here.
	logic                pend_vld_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic                pend_clr_q;
	logic [SLOT_W-1:0]   pend_free_q;

	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_clr_q;
	logic [SLOT_W-1:0]   out_free_q;
	logic                out_last_q;

	tbl_rd_t             tbl_rd;
	tbl_wr_t             tbl_wr;
	slot_entry_t         tbl_rd_data_w;
	slot_entry_t         ent;

	logic                in_fire;
	logic                cfg_fire;
	logic                out_free;
	logic                scanning;
	logic                stall;
	logic                eval;
	logic                hit;
	logic                do_wr;
	logic                is_rel;
	logic                at_end;
	logic                finish;
	logic                issue;
	logic                emit_mid;
	logic                emit_done;
	logic [SLOT_W-1:0]   sat_free;
	logic [SLOT_W-1:0]   new_free;
	slot_entry_t         wr_entry;

	logic [HANDLE_W-1:0] in_handle;
	logic [SLOT_W-1:0]   in_slot;
	logic                slot_ok;
	logic                go_scan;
	logic [SLOT_W-1:0]   start_addr;
	logic [SLOT_W-1:0]   stop_addr;

	assign in_handle     = s_axis_tdata[HANDLE_W-1:0];
	assign in_slot       = s_axis_tdata[HANDLE_W +: SLOT_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign scanning      = (state_q == ST_SCAN);

	assign slot_ok = (in_slot != '0) && (in_slot <= active_q);

	// Decide at acceptance whether the command needs the table at all.
	always_comb begin
		go_scan    = 1'b0;
		start_addr = SLOT_W'(1);
		stop_addr  = active_q;
		unique case (s_axis_tuser)
			M_RESERVE: begin
				go_scan = (free_count_q != '0) && (active_q != '0);
			end
			M_LOOKUP, M_DESTROY: begin
				go_scan = (in_handle != '0) && (active_q != '0);
			end
			M_REF_REL, M_ABORT_REL: begin
				go_scan    = slot_ok;
				start_addr = in_slot;
				stop_addr  = in_slot;
			end
			M_SWEEP: begin
				go_scan = (active_q != '0);
			end
			default: begin
				go_scan = 1'b0;
			end
		endcase
	end

	assign ent      = tbl_rd_data_w;
	assign is_rel   = (ent.state == SS_RELEASED);
	assign sat_free = (free_count_q < active_q) ? free_count_q + SLOT_W'(1) : free_count_q;
	assign at_end   = (ev_addr_s1 == end_q);

	// A sweep hit that must push the previous hit out waits for the output.
	assign stall = scanning && ev_vld_s1 && (mode_q == M_SWEEP) && is_rel &&
		pend_vld_q && !out_free;
	assign eval  = scanning && ev_vld_s1 && !stall;

	// The one evaluation unit: compare the entry and form the update.
	always_comb begin
		hit      = 1'b0;
		do_wr    = 1'b0;
		new_free = free_count_q;
		wr_entry = ent;
		unique case (mode_q)
			M_RESERVE: begin
				hit            = (ent.state == SS_AVAILABLE);
				do_wr          = hit;
				wr_entry.state = SS_ASSIGNED;
				wr_entry.owner = handle_q;
				if (hit) begin
					new_free = free_count_q - SLOT_W'(1);
				end
			end
			M_LOOKUP: begin
				hit = (ent.owner == handle_q);
			end
			M_DESTROY: begin
				hit            = (ent.owner == handle_q);
				do_wr          = hit;
				wr_entry.state = SS_KILLED;
				wr_entry.owner = '0;
			end
			M_REF_REL: begin
				hit            = 1'b1;
				do_wr          = 1'b1;
				wr_entry.state = SS_RELEASED;
			end
			M_ABORT_REL: begin
				hit            = 1'b1;
				do_wr          = (ent.state != SS_AVAILABLE);
				wr_entry.state = SS_AVAILABLE;
				if (do_wr) begin
					new_free = sat_free;
				end
			end
			M_SWEEP: begin
				do_wr          = is_rel;
				wr_entry.state = SS_AVAILABLE;
				if (is_rel) begin
					new_free = sat_free;
				end
			end
			default: begin
				hit = 1'b1;
			end
		endcase
	end

	assign finish    = eval && (hit || at_end);
	assign issue     = scanning && !stall && !finish && (iss_addr_q <= {1'b0, end_q});
	assign emit_mid  = eval && (mode_q == M_SWEEP) && is_rel && pend_vld_q;
	assign emit_done = (state_q == ST_DONE) && out_free;

	assign tbl_rd.en    = issue;
	assign tbl_rd.addr  = iss_addr_q[SLOT_W-1:0];
	assign tbl_wr.en    = eval && do_wr;
	assign tbl_wr.addr  = ev_addr_s1;
	assign tbl_wr.entry = wr_entry;

	ksa_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (tbl_rd),
		.wr      (tbl_wr),
		.rd_data (tbl_rd_data_w)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= SLOT_W'(MAX_SLOTS);
			free_count_q <= SLOT_W'(MAX_SLOTS);
			ev_vld_s1    <= 1'b0;
			pend_vld_q   <= 1'b0;
		end else begin
			if (cfg_fire) begin
				active_q     <= cfg_data;
				free_count_q <= cfg_data;
			end else if (eval) begin
				free_count_q <= new_free;
			end
			if (!stall) begin
				ev_vld_s1 <= issue;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						pend_vld_q <= 1'b0;
						state_q    <= go_scan ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (eval && (mode_q == M_SWEEP) && is_rel) begin
						pend_vld_q <= 1'b1;
					end
					if (finish) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command and scan payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q      <= s_axis_tuser;
			handle_q    <= in_handle;
			iss_addr_q  <= {1'b0, start_addr};
			end_q       <= stop_addr;
			pend_slot_q <= '0;
			pend_clr_q  <= 1'b0;
			pend_free_q <= free_count_q;
		end else begin
			if (issue) begin
				iss_addr_q <= iss_addr_q + (SLOT_W+1)'(1);
				ev_addr_s1 <= iss_addr_q[SLOT_W-1:0];
			end
			if (eval) begin
				if (mode_q == M_SWEEP) begin
					if (is_rel) begin
						pend_slot_q <= ev_addr_s1;
						pend_clr_q  <= 1'b1;
						pend_free_q <= new_free;
					end
				end else if (hit) begin
					pend_slot_q <= ev_addr_s1;
					pend_free_q <= new_free;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_mid || emit_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_mid || emit_done) begin
			out_slot_q <= pend_slot_q;
			out_clr_q  <= pend_clr_q;
			out_free_q <= pend_free_q;
			out_last_q <= emit_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_free_q, out_slot_q};
	assign m_axis_tuser  = out_clr_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// The free count never exceeds the number of active slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= active_q)
		else $error("free count above active slot count");

	// Table data is only evaluated while a scan is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		ev_vld_s1 |-> (state_q == ST_SCAN))
		else $error("table entry evaluated outside a scan");

	// A clear request always names a real slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[SLOT_W-1:0] != '0))
		else $error("clear request for slot zero");

	// A stalled sweep must not write the table or advance the scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (!tbl_wr.en && !tbl_rd.en))
		else $error("table access during output stall");
`endif

endmodule

`default_nettype wire

// ----- sv/ksa_slot_table.sv -----
// Slot table memory with per-entry valid bits that reset to the empty entry.
`timescale 1ns / 1ps
`default_nettype none

module ksa_slot_table (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire ksa_pkg::tbl_rd_t rd,
	input  wire ksa_pkg::tbl_wr_t wr,
	output ksa_pkg::slot_entry_t  rd_data
);
	import ksa_pkg::*;

	slot_entry_t            mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0]   valid_q;
	slot_entry_t            mem_rd_q;
	logic                   valid_rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd.en) begin
			mem_rd_q <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				valid_rd_q <= valid_q[rd.addr];
			end
		end
	end

	// An entry never written since reset reads as available with no owner.
	assign rd_data = valid_rd_q ? mem_rd_q : '0;

endmodule

`default_nettype wire
